FILE: rtl/core/sphere_uv_map_macros.svh
// assertion macros shared by the sphere uv mapping rtl
// expects clk and arst_n in the scope of each use
`ifndef SPHERE_UV_MAP_MACROS_SVH
`define SPHERE_UV_MAP_MACROS_SVH

// clocked property, off while in reset
`define SUVM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define SUVM_ASSERT_IMPL(lbl, ante, cons, msg) \
	`SUVM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/suvm_pkg.sv
// shared constants, types and functions of the sphere uv mapping block
// no dependencies
`timescale 1ns / 1ps

package suvm_pkg;

	localparam int COORD_BITS    = 24;
	localparam int UV_BITS       = 16;
	localparam int CORDIC_STAGES = 18;
	localparam int GUARD         = 24;
	localparam int TAB_LEN       = 28;

	// normalized coordinates: largest magnitude in [2^30, 2^31)
	localparam int MAG_BITS  = 32;
	localparam int NORM_BITS = MAG_BITS + 1;
	localparam int SH_BITS   = $clog2(MAG_BITS - 1);
	localparam int NORM_TOP  = MAG_BITS - 2;

	// cordic datapath and angles (full turn is 2^ANG_BITS)
	localparam int CW        = NORM_BITS + GUARD + 3;
	localparam int ANG_BITS  = 32;
	localparam int CIDX_BITS = $clog2(TAB_LEN);

	// square root of x*x + z*z, one result bit per cell
	localparam int SQ_BITS     = 2 * MAG_BITS;
	localparam int SQRT_STAGES = SQ_BITS / 2;
	localparam int QIDX_BITS   = $clog2(SQRT_STAGES);

	localparam logic [ANG_BITS-1:0] ANG_HALF = ANG_BITS'(1) << (ANG_BITS - 1);
	localparam logic [ANG_BITS-1:0] ANG_QTR  = ANG_BITS'(1) << (ANG_BITS - 2);
	localparam logic [ANG_BITS-1:0] ANG_3QTR = ANG_HALF | ANG_QTR;
	localparam logic [ANG_BITS:0]   ANG_FULL = (ANG_BITS + 1)'(1) << ANG_BITS;

	typedef struct packed {
		logic                        vld;
		logic                        zero;
		logic signed [NORM_BITS-1:0] x;
		logic signed [NORM_BITS-1:0] y;
		logic signed [NORM_BITS-1:0] z;
	} norm_t;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic [ANG_BITS-1:0]  ang;
	} cordic_t;

	typedef struct packed {
		logic [SQ_BITS-1:0] n;
		logic [SQ_BITS-1:0] res;
	} sqrt_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic [ANG_BITS-1:0] atan_turn(input logic [CIDX_BITS-1:0] i);
		logic [ANG_BITS-1:0] t;
		unique case (i)
			5'd0:    t = 32'd536870912;
			5'd1:    t = 32'd316933406;
			5'd2:    t = 32'd167458907;
			5'd3:    t = 32'd85004756;
			5'd4:    t = 32'd42667331;
			5'd5:    t = 32'd21354465;
			5'd6:    t = 32'd10679838;
			5'd7:    t = 32'd5340245;
			5'd8:    t = 32'd2670163;
			5'd9:    t = 32'd1335087;
			5'd10:   t = 32'd667544;
			5'd11:   t = 32'd333772;
			5'd12:   t = 32'd166886;
			5'd13:   t = 32'd83443;
			5'd14:   t = 32'd41722;
			5'd15:   t = 32'd20861;
			5'd16:   t = 32'd10430;
			5'd17:   t = 32'd5215;
			5'd18:   t = 32'd2608;
			5'd19:   t = 32'd1304;
			5'd20:   t = 32'd652;
			5'd21:   t = 32'd326;
			5'd22:   t = 32'd163;
			5'd23:   t = 32'd81;
			5'd24:   t = 32'd41;
			5'd25:   t = 32'd20;
			5'd26:   t = 32'd10;
			5'd27:   t = 32'd5;
			default: t = '0;
		endcase
		return t;
	endfunction

	// turn fraction to texture code, round half up, saturate at the largest code
	function automatic logic [UV_BITS-1:0] to_uv(input logic [ANG_BITS:0] w);
		logic [ANG_BITS:0] r;
		r = (w + ((ANG_BITS + 1)'(1) << (ANG_BITS - 1 - UV_BITS))) >> (ANG_BITS - UV_BITS);
		if (r > (ANG_BITS + 1)'((64'd1 << UV_BITS) - 64'd1)) begin
			return '1;
		end
		return r[UV_BITS-1:0];
	endfunction

endpackage

FILE: rtl/core/suvm_norm.sv
// front end: zero check and common normalizing shift of the three coordinates
// depends on suvm_pkg
`timescale 1ns / 1ps

module suvm_norm (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_vld,
	input  logic signed [suvm_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [suvm_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [suvm_pkg::COORD_BITS-1:0] point_z,
	output suvm_pkg::norm_t                        nrm_o
);
	import suvm_pkg::*;

	logic [COORD_BITS-1:0] xm, ym, zm, mx;
	logic                  vld_s1, vld_s2, zero_s1, zero_s2;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic [COORD_BITS-1:0] m_s1;
	logic [SH_BITS-1:0]    sh, sh_s2;

	// magnitudes and their maximum
	always_comb begin
		xm = point_x[COORD_BITS-1] ? COORD_BITS'(-point_x) : COORD_BITS'(point_x);
		ym = point_y[COORD_BITS-1] ? COORD_BITS'(-point_y) : COORD_BITS'(point_y);
		zm = point_z[COORD_BITS-1] ? COORD_BITS'(-point_z) : COORD_BITS'(point_z);
		mx = xm;
		if (ym > mx) begin
			mx = ym;
		end
		if (zm > mx) begin
			mx = zm;
		end
	end

	// shift that brings the leading one of the maximum to the normalized top bit
	always_comb begin
		sh = '0;
		for (int i = 0; i < COORD_BITS; i++) begin
			if (m_s1[i]) begin
				sh = SH_BITS'(NORM_TOP - i);
			end
		end
	end

	// control pipeline and normalized output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			nrm_o  <= '0;
		end else begin
			vld_s1     <= in_vld;
			vld_s2     <= vld_s1;
			nrm_o.vld  <= vld_s2;
			nrm_o.zero <= zero_s2;
			nrm_o.x    <= NORM_BITS'(x_s2) <<< sh_s2;
			nrm_o.y    <= NORM_BITS'(y_s2) <<< sh_s2;
			nrm_o.z    <= NORM_BITS'(z_s2) <<< sh_s2;
		end
	end

	// data pipeline
	always_ff @(posedge clk) begin
		x_s1    <= point_x;
		y_s1    <= point_y;
		z_s1    <= point_z;
		m_s1    <= mx;
		zero_s1 <= (point_x == '0) && (point_y == '0) && (point_z == '0);
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		z_s2    <= z_s1;
		zero_s2 <= zero_s1;
		sh_s2   <= sh;
	end

endmodule

FILE: rtl/core/suvm_sqrt_cell.sv
// one cell of the square root chain: settles one result bit per cycle
// depends on suvm_pkg
`timescale 1ns / 1ps

module suvm_sqrt_cell (
	input  logic                            clk,
	input  logic [suvm_pkg::QIDX_BITS-1:0]  idx,
	input  suvm_pkg::sqrt_t                 d_i,
	output suvm_pkg::sqrt_t                 d_o
);
	import suvm_pkg::*;

	logic [SQ_BITS-1:0] bitv;
	logic [SQ_BITS:0]   trial;
	sqrt_t              nxt;

	// restoring step: try the next result bit against the remainder
	always_comb begin
		bitv  = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * int'(idx));
		trial = {1'b0, d_i.res} + {1'b0, bitv};
		if ({1'b0, d_i.n} >= trial) begin
			nxt.n   = d_i.n - trial[SQ_BITS-1:0];
			nxt.res = (d_i.res >> 1) + bitv;
		end else begin
			nxt.n   = d_i.n;
			nxt.res = d_i.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		d_o <= nxt;
	end

endmodule

FILE: rtl/core/suvm_cordic_cell.sv
// one vectoring cordic micro-rotation, registered
// depends on suvm_pkg
`timescale 1ns / 1ps

module suvm_cordic_cell (
	input  logic                            clk,
	input  logic [suvm_pkg::CIDX_BITS-1:0]  idx,
	input  suvm_pkg::cordic_t               d_i,
	output suvm_pkg::cordic_t               d_o
);
	import suvm_pkg::*;

	logic signed [CW-1:0] da, db;
	logic                 bpos;
	cordic_t              nxt;

	// rotate toward the positive a axis, accumulate the angle
	always_comb begin
		da   = d_i.b >>> idx;
		db   = d_i.a >>> idx;
		bpos = !d_i.b[CW-1] && (d_i.b != '0);
		if (bpos) begin
			nxt.a   = d_i.a + da;
			nxt.b   = d_i.b - db;
			nxt.ang = d_i.ang + atan_turn(idx);
		end else begin
			nxt.a   = d_i.a - da;
			nxt.b   = d_i.b + db;
			nxt.ang = d_i.ang - atan_turn(idx);
		end
	end

	always_ff @(posedge clk) begin
		d_o <= nxt;
	end

endmodule

FILE: rtl/core/sphere_uv_map.sv
// top level of the sphere uv mapping block
// depends on suvm_pkg, suvm_norm, suvm_sqrt_cell, suvm_cordic_cell, sphere_uv_map_macros.svh
`timescale 1ns / 1ps
// Usage:
//   A point (point_x, point_y, point_z, signed Q11.12 relative to the sphere
//   center) is taken at a clock edge with start high and busy low. busy is
//   always low: a new point may be given in every cycle.
//   Each point gives one result beat: done is high for exactly one cycle with
//   u_coord, v_coord (unsigned Q0.16) and zero_vector. The receiver cannot
//   stall; results must be taken as they appear.
//   A point passes three normalize stages, squares and sum, one cell per
//   square root bit (32), then the v angle cordic chain of one cell per
//   micro-rotation. The u angle runs its own cordic chain in parallel and
//   waits in a delay line. Throughput is one point per cycle, results in
//   input order.
//   A zero vector gives zero coordinates with zero_vector high.
//   Reset clears all valid bits, so no result is invented across it;
//   points in flight at reset are dropped.

module sphere_uv_map (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [suvm_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [suvm_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [suvm_pkg::COORD_BITS-1:0] point_z,
	output logic                                   done,
	output logic [suvm_pkg::UV_BITS-1:0]           u_coord,
	output logic [suvm_pkg::UV_BITS-1:0]           v_coord,
	output logic                                   zero_vector
);
	import suvm_pkg::*;

	`include "sphere_uv_map_macros.svh"

	localparam int UDLY = SQRT_STAGES + 2;
	localparam int VLEN = SQRT_STAGES + 2 + CORDIC_STAGES;

	norm_t nrm;

	logic                        xneg;
	logic signed [NORM_BITS-1:0] ux, uz;
	logic [MAG_BITS-1:0]         xa, ya, za, nrm_or;
	cordic_t                     ucord [CORDIC_STAGES+1];
	cordic_t                     vcord [CORDIC_STAGES+1];
	sqrt_t                       sq [SQRT_STAGES+1];
	logic [3:0]                  ufl_q [CORDIC_STAGES];
	logic [2:0]                  vfl_q [CORDIC_STAGES];
	logic [UV_BITS-1:0]          udl_q [UDLY];
	logic signed [NORM_BITS-1:0] ydl_q [UDLY];
	logic                        vld_q [VLEN];
	logic                        zro_q [VLEN];
	logic [SQ_BITS-1:0]          xx_q, zz_q, sum_q;
	logic [ANG_BITS-1:0]         ua;
	logic [ANG_BITS:0]           wu, wv;
	logic [MAG_BITS-1:0]         r;
	logic signed [NORM_BITS-1:0] yv;
	logic signed [ANG_BITS:0]    phi;
	logic signed [ANG_BITS+2:0]  vv;
	logic                        u_xneg, u_zzero, u_xzero, u_zpos;
	logic                        v_yzero, v_yneg, v_rzero;

	assign busy = 1'b0;

	suvm_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.nrm_o   (nrm)
	);

	// magnitudes and u cordic operands, folded into the right half plane
	always_comb begin
		xneg   = nrm.x[NORM_BITS-1];
		ux     = xneg ? -nrm.x : nrm.x;
		uz     = xneg ? -nrm.z : nrm.z;
		xa     = MAG_BITS'(ux);
		ya     = nrm.y[NORM_BITS-1] ? MAG_BITS'(-nrm.y) : MAG_BITS'(nrm.y);
		za     = nrm.z[NORM_BITS-1] ? MAG_BITS'(-nrm.z) : MAG_BITS'(nrm.z);
		nrm_or = xa | ya | za;
	end

	assign ucord[0].a   = CW'(ux) <<< GUARD;
	assign ucord[0].b   = CW'(uz) <<< GUARD;
	assign ucord[0].ang = '0;

	// u angle chain
	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_ucell
		suvm_cordic_cell u_cell (
			.clk (clk),
			.idx (CIDX_BITS'(j)),
			.d_i (ucord[j]),
			.d_o (ucord[j+1])
		);
	end

	// squares, sum, then the root chain
	always_ff @(posedge clk) begin
		xx_q  <= xa * xa;
		zz_q  <= za * za;
		sum_q <= xx_q + zz_q;
	end

	assign sq[0].n   = sum_q;
	assign sq[0].res = '0;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_qcell
		suvm_sqrt_cell u_cell (
			.clk (clk),
			.idx (QIDX_BITS'(k)),
			.d_i (sq[k]),
			.d_o (sq[k+1])
		);
	end

	// v cordic operands: (radius, y)
	always_comb begin
		r  = sq[SQRT_STAGES].res[MAG_BITS-1:0];
		yv = ydl_q[UDLY-1];
	end

	assign vcord[0].a   = CW'($signed({1'b0, r})) <<< GUARD;
	assign vcord[0].b   = CW'(yv) <<< GUARD;
	assign vcord[0].ang = '0;

	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_vcell
		suvm_cordic_cell u_cell (
			.clk (clk),
			.idx (CIDX_BITS'(j)),
			.d_i (vcord[j]),
			.d_o (vcord[j+1])
		);
	end

	// u angle with axis and seam cases, then turn fraction
	always_comb begin
		{u_xneg, u_zzero, u_xzero, u_zpos} = ufl_q[CORDIC_STAGES-1];
		if (u_zzero) begin
			ua = u_xneg ? ANG_HALF : '0;
		end else if (u_xzero) begin
			ua = u_zpos ? ANG_QTR : ANG_3QTR;
		end else begin
			ua = ucord[CORDIC_STAGES].ang + (u_xneg ? ANG_HALF : '0);
		end
		wu = (ua == ANG_HALF) ? ANG_FULL : {1'b0, ua + ANG_HALF};
	end

	// v from the elevation angle, clamped to one turn
	always_comb begin
		{v_yzero, v_yneg, v_rzero} = vfl_q[CORDIC_STAGES-1];
		if (v_yzero) begin
			phi = '0;
		end else if (v_rzero) begin
			phi = v_yneg ? -$signed({1'b0, ANG_QTR}) : $signed({1'b0, ANG_QTR});
		end else begin
			phi = (ANG_BITS + 1)'($signed(vcord[CORDIC_STAGES].ang));
		end
		vv = $signed({2'b00, 1'b0, ANG_HALF}) - ((ANG_BITS + 3)'(phi) <<< 1);
		if (vv[ANG_BITS+2]) begin
			wv = '0;
		end else if (vv > $signed({2'b00, ANG_FULL})) begin
			wv = ANG_FULL;
		end else begin
			wv = vv[ANG_BITS:0];
		end
	end

	// side data delay lines
	always_ff @(posedge clk) begin
		ufl_q[0] <= {xneg, nrm.z == '0, nrm.x == '0, !nrm.z[NORM_BITS-1]};
		vfl_q[0] <= {yv == '0, yv[NORM_BITS-1], r == '0};
		udl_q[0] <= to_uv(wu);
		ydl_q[0] <= nrm.y;
		zro_q[0] <= nrm.zero;
		for (int i = 1; i < CORDIC_STAGES; i++) begin
			ufl_q[i] <= ufl_q[i-1];
			vfl_q[i] <= vfl_q[i-1];
		end
		for (int i = 1; i < UDLY; i++) begin
			udl_q[i] <= udl_q[i-1];
			ydl_q[i] <= ydl_q[i-1];
		end
		for (int i = 1; i < VLEN; i++) begin
			zro_q[i] <= zro_q[i-1];
		end
	end

	// valid bits of the beat in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VLEN; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= nrm.vld;
			for (int i = 1; i < VLEN; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done        <= 1'b0;
			zero_vector <= 1'b0;
		end else begin
			done        <= vld_q[VLEN-1];
			zero_vector <= vld_q[VLEN-1] && zro_q[VLEN-1];
		end
	end

	always_ff @(posedge clk) begin
		u_coord <= zro_q[VLEN-1] ? '0 : udl_q[UDLY-1];
		v_coord <= zro_q[VLEN-1] ? '0 : to_uv(wv);
	end

	`SUVM_ASSERT_IMPL(a_norm_range, nrm.vld && !nrm.zero, nrm_or[MAG_BITS-1:MAG_BITS-2] != '0, "normalized magnitude out of range")
	`SUVM_ASSERT_IMPL(a_zero_coords, done && zero_vector, u_coord == '0 && v_coord == '0, "zero vector with nonzero coordinates")
	`SUVM_ASSERT_IMPL(a_zero_strobe, zero_vector, done, "zero flag outside a result beat")

endmodule
